[src/eab_pkg.sv]
// Package with the constants, tables and types shared by the Euler-angle basis block.
package eab_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRACTION_BITS = 14;
    localparam int TABLE_LEN     = 24;
    localparam int Q30_BITS      = 33;
    localparam int OUT_BITS      = FRACTION_BITS + 2;

    localparam logic signed [Q30_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef logic signed [Q30_BITS-1:0] trig_t;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic [15:0] roll;
        logic        kind;
    } angles_t;

    typedef struct packed {
        trig_t sp;
        trig_t cp;
        trig_t sy;
        trig_t cy;
        trig_t sr;
        trig_t cr;
        logic  kind;
    } trig_set_t;

    function automatic logic [31:0] atan_turns(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'd536870912;
                1: v = 32'd316933406;
                2: v = 32'd167458907;
                3: v = 32'd85004756;
                4: v = 32'd42667331;
                5: v = 32'd21354465;
                6: v = 32'd10679838;
                7: v = 32'd5340245;
                8: v = 32'd2670163;
                9: v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                default: v = 32'd81;
            endcase
            return v;
        end
    endfunction

endpackage

[src/eab_front.sv]
// Front part: accepts angle beats and turns each angle into a sine and cosine pair
// through a pipelined CORDIC, one round per stage.
module eab_front #(
    parameter int CORDIC_ROUNDS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  eab_pkg::angles_t   in_data,
    input  logic               advance,
    output logic               out_valid,
    output eab_pkg::trig_set_t out_data
);

    localparam int ST = CORDIC_ROUNDS + 1;

    typedef struct packed {
        logic signed [eab_pkg::Q30_BITS-1:0] x;
        logic signed [eab_pkg::Q30_BITS-1:0] y;
        logic signed [32:0]                  z;
        logic [1:0]                          q;
    } cord_t;

    cord_t       p_reg [0:ST-1][0:2];
    cord_t       p_next[0:ST-1][0:2];
    logic        kind_reg [0:ST-1];
    logic [ST-1:0] valid_reg;

    // Quarter-turn reduction feeds stage zero.
    always_comb
    begin
        logic [eab_pkg::ANGLE_BITS-1:0] ang;
        logic [31:0] a;
        logic [31:0] u;
        for (int k = 0; k < 3; k++)
        begin
            ang = (k == 0) ? in_data.pitch[eab_pkg::ANGLE_BITS-1:0] :
                  (k == 1) ? in_data.yaw[eab_pkg::ANGLE_BITS-1:0] :
                             in_data.roll[eab_pkg::ANGLE_BITS-1:0];
            a = 32'(ang) << (32 - eab_pkg::ANGLE_BITS);
            u = a + 32'h2000_0000;
            p_next[0][k].q = u[31:30];
            p_next[0][k].z = $signed({3'b000, u[29:0]}) - 33'sh0_2000_0000;
            p_next[0][k].x = eab_pkg::CORDIC_GAIN;
            p_next[0][k].y = '0;
        end
        for (int s = 1; s < ST; s++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (p_reg[s-1][k].z >= 0)
                begin
                    p_next[s][k].x = p_reg[s-1][k].x - (p_reg[s-1][k].y >>> (s - 1));
                    p_next[s][k].y = p_reg[s-1][k].y + (p_reg[s-1][k].x >>> (s - 1));
                    p_next[s][k].z = p_reg[s-1][k].z
                        - $signed({1'b0, eab_pkg::atan_turns(s - 1)});
                end
                else
                begin
                    p_next[s][k].x = p_reg[s-1][k].x + (p_reg[s-1][k].y >>> (s - 1));
                    p_next[s][k].y = p_reg[s-1][k].y - (p_reg[s-1][k].x >>> (s - 1));
                    p_next[s][k].z = p_reg[s-1][k].z
                        + $signed({1'b0, eab_pkg::atan_turns(s - 1)});
                end
                p_next[s][k].q = p_reg[s-1][k].q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[ST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < ST; s++)
            begin
                p_reg[s] <= p_next[s];
            end
            kind_reg[0] <= in_data.kind;
            for (int s = 1; s < ST; s++)
            begin
                kind_reg[s] <= kind_reg[s-1];
            end
        end
    end

    // Exact quarter-turn fixup by swap and negation.
    always_comb
    begin
        eab_pkg::trig_t s_v [0:2];
        eab_pkg::trig_t c_v [0:2];
        for (int k = 0; k < 3; k++)
        begin
            unique case (p_reg[ST-1][k].q)
                2'd0:
                begin
                    c_v[k] = p_reg[ST-1][k].x;
                    s_v[k] = p_reg[ST-1][k].y;
                end
                2'd1:
                begin
                    c_v[k] = -p_reg[ST-1][k].y;
                    s_v[k] = p_reg[ST-1][k].x;
                end
                2'd2:
                begin
                    c_v[k] = -p_reg[ST-1][k].x;
                    s_v[k] = -p_reg[ST-1][k].y;
                end
                default:
                begin
                    c_v[k] = p_reg[ST-1][k].y;
                    s_v[k] = -p_reg[ST-1][k].x;
                end
            endcase
        end
        out_data.sp   = s_v[0];
        out_data.cp   = c_v[0];
        out_data.sy   = s_v[1];
        out_data.cy   = c_v[1];
        out_data.sr   = s_v[2];
        out_data.cr   = c_v[2];
        out_data.kind = kind_reg[ST-1];
    end

    assign out_valid = valid_reg[ST-1];

endmodule

[src/eab_queue.sv]
// Short queue between the trig front and the matrix back.
module eab_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  eab_pkg::trig_set_t wr_data,
    input  logic               rd_en,
    output logic               rd_valid,
    output eab_pkg::trig_set_t rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);

    eab_pkg::trig_set_t mem_reg [0:DEPTH-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    assign rd_data  = mem_reg[rp_reg];
    assign rd_valid = (cnt_reg != '0);
    assign count    = cnt_reg;

endmodule

[src/eab_back.sv]
// Back part: multiplies the trig values into the nine components and rounds them.
module eab_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  eab_pkg::trig_set_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [eab_pkg::OUT_BITS*9-1:0] out_data
);

    localparam int W = eab_pkg::Q30_BITS;
    localparam int P = 2 * W;

    typedef logic signed [P-1:0] prod_t;

    // Stage 1: rounded sr*sp, cr*sp and the products needing no rounded term.
    logic        v1_reg, v2_reg, v3_reg;
    logic        k1_reg, k2_reg;
    eab_pkg::trig_t sy1_reg, cy1_reg, sp1_reg;
    eab_pkg::trig_t srsp_reg, crsp_reg;
    prod_t m00_reg, m01_reg, crsy_reg, crcy_reg, srsy_reg, srcy_reg, e_reg, f_reg;
    prod_t p00_reg, p01_reg, p02_reg, pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic        stall;
    logic [eab_pkg::OUT_BITS*9-1:0] o_reg;

    function automatic eab_pkg::trig_t rnd30(input prod_t p);
        prod_t t;
        begin
            t = (p + (prod_t'(1) <<< 29)) >>> 30;
            return t[W-1:0];
        end
    endfunction

    function automatic logic [eab_pkg::OUT_BITS-1:0] to_out(input prod_t v);
        prod_t r;
        prod_t lim;
        begin
            lim = prod_t'(1) <<< eab_pkg::FRACTION_BITS;
            r = (v + (prod_t'(1) <<< (59 - eab_pkg::FRACTION_BITS)))
                >>> (60 - eab_pkg::FRACTION_BITS);
            if (r > lim)
            begin
                r = lim;
            end
            if (r < -lim)
            begin
                r = -lim;
            end
            return r[eab_pkg::OUT_BITS-1:0];
        end
    endfunction

    assign stall    = v3_reg && !out_ready;
    assign in_ready = !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (!stall)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            srsp_reg <= rnd30(in_data.sr * in_data.sp);
            crsp_reg <= rnd30(in_data.cr * in_data.sp);
            m00_reg  <= in_data.cp * in_data.cy;
            m01_reg  <= in_data.cp * in_data.sy;
            crsy_reg <= in_data.cr * in_data.sy;
            crcy_reg <= in_data.cr * in_data.cy;
            srsy_reg <= in_data.sr * in_data.sy;
            srcy_reg <= in_data.sr * in_data.cy;
            e_reg    <= in_data.sr * in_data.cp;
            f_reg    <= in_data.cr * in_data.cp;
            sy1_reg  <= in_data.sy;
            cy1_reg  <= in_data.cy;
            sp1_reg  <= in_data.sp;
            k1_reg   <= in_data.kind;

            p00_reg <= m00_reg;
            p01_reg <= m01_reg;
            p02_reg <= -(prod_t'(sp1_reg) <<< 30);
            pa_reg  <= srsp_reg * cy1_reg - crsy_reg;
            pb_reg  <= srsp_reg * sy1_reg + crcy_reg;
            pc_reg  <= crsp_reg * cy1_reg + srsy_reg;
            pd_reg  <= crsp_reg * sy1_reg - srcy_reg;
            pe_reg  <= e_reg;
            pf_reg  <= f_reg;
            k2_reg  <= k1_reg;

            if (!k2_reg)
            begin
                o_reg <= {to_out(pf_reg), to_out(pd_reg), to_out(pc_reg),
                          to_out(-pe_reg), to_out(-pb_reg), to_out(-pa_reg),
                          to_out(p02_reg), to_out(p01_reg), to_out(p00_reg)};
            end
            else
            begin
                o_reg <= {to_out(pf_reg), to_out(pe_reg), to_out(p02_reg),
                          to_out(pd_reg), to_out(pb_reg), to_out(p01_reg),
                          to_out(pc_reg), to_out(pa_reg), to_out(p00_reg)};
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = o_reg;

endmodule

[src/euler_angles_to_basis_vectors_top.sv]
// Top level of the Euler-angle to basis-vector converter.
// The block takes one beat of pitch, yaw and roll (binary angles, a full turn is
// 2^ANGLE_BITS) and returns one beat with the forward, right and up vectors as nine
// signed Q2.14 components, rounded to nearest and clamped to +-1. A tuser bit of one
// selects the transposed layout with the right vector negated. A new beat is taken
// every cycle while tready is high; latency is set by the one-round-per-stage CORDIC
// pipeline in the front part and three multiply and round stages in the back part. A
// small queue between the two parts lets the front keep running while the output is
// stalled; the front is held only when the queue could not take what is in flight.
module euler_angles_to_basis_vectors_top #(
    parameter int CORDIC_ROUNDS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // pitch[15:0], yaw[31:16], roll[47:32]
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // forward_x..up_z, 16 bits each from bit 0
);

    localparam int QDEPTH = 4;

    eab_pkg::angles_t   ang;
    eab_pkg::trig_set_t f_data, q_data;
    logic f_valid, q_valid, b_ready, advance, q_rd;
    logic [$clog2(QDEPTH+1)-1:0] q_count;

    assign ang.pitch = s_axis_tdata[15:0];
    assign ang.yaw   = s_axis_tdata[31:16];
    assign ang.roll  = s_axis_tdata[47:32];
    assign ang.kind  = s_axis_tuser;

    // The front advances when the queue has room for the beat leaving it.
    assign q_rd    = q_valid && b_ready;
    assign advance = !f_valid || (q_count < ($clog2(QDEPTH+1))'(QDEPTH)) || q_rd;
    assign s_axis_tready = advance;

    eab_front #(
        .CORDIC_ROUNDS(CORDIC_ROUNDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_data  (ang),
        .advance  (advance),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    eab_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid && advance),
        .wr_data (f_data),
        .rd_en   (q_rd),
        .rd_valid(q_valid),
        .rd_data (q_data),
        .count   (q_count)
    );

    eab_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_data  (q_data),
        .in_ready (b_ready),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule
